// File: hdl/smrt_pkg.sv
// ============================================================================
// Range table package
// Shared types and codes for the sorted, merged range table.
// ============================================================================
package smrt_pkg;

  // One stored range, lower bound in the upper half of the word.
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } span_t;

  // Operation codes of an input beat.
  localparam logic OpInsert = 1'b0;
  localparam logic OpRead   = 1'b1;

  // Status codes of a result beat.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_MERGE,
    S_INS_FLUSH,
    S_RD_REQ,
    S_RD_DATA,
    S_RESP
  } smrt_state_e;

  // Flags of the shared compare unit.
  typedef struct packed {
    logic after;    // a sorts after b
    logic touch;    // b overlaps or is adjacent to a
    logic hi_less;  // a.hi below b.hi
  } cmp_res_t;

endpackage

// File: hdl/smrt_cmp.sv
// ============================================================================
// Range compare unit
// Sort order, adjacency and upper-bound compare on two ranges.
// ============================================================================
module smrt_cmp (
  input  smrt_pkg::span_t    a_i,
  input  smrt_pkg::span_t    b_i,
  output smrt_pkg::cmp_res_t res_o
);
  import smrt_pkg::*;

  // A lower bound of zero always touches; otherwise lo - 1 never wraps.
  assign res_o.after   = {a_i.lo, a_i.hi} > {b_i.lo, b_i.hi};
  assign res_o.touch   = (b_i.lo == 32'd0) || (a_i.hi >= (b_i.lo - 32'd1));
  assign res_o.hi_less = a_i.hi < b_i.hi;

endmodule

// File: hdl/smrt_store.sv
// ============================================================================
// Range store
// One write port and one registered read port over the range entries.
// ============================================================================
module smrt_store #(
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [AddrW-1:0]       wr_addr_i,
  input  smrt_pkg::span_t        wr_data_i,
  input  logic                   rd_en_i,
  input  logic [AddrW-1:0]       rd_addr_i,
  output smrt_pkg::span_t        rd_data_o
);
  import smrt_pkg::*;

  span_t mem_q [Depth];
  span_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/sorted_merged_range_table.sv
// ============================================================================
// Sorted merged range table
// Keeps 32-bit ranges sorted by lower then upper bound, folds overlapping or
// adjacent ranges on insert, and reads back one entry by index.
// ============================================================================
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+---------------------------
//   in      | to block  | in_valid_i / in_stall_o   | operation, range_low,
//           |           |                           | range_high, entry_index
//   out     | from block| out_valid_o / out_stall_i | status, entry_count,
//           |           |                           | entry_low, entry_high
//
// An insert into a table of n entries stalls the input while the n + 1 beats
// of the merge stream each pass a compare and a merge step on the single
// compare unit and the one store read port. A read passes a store request and
// a data capture, a refused item neither. Reset clears the count and the
// sequencer; the store is not cleared, since only entries below the count
// are ever read. A stalled result adds cycles only when the next one is ready.
//
// Insert works as one merge pass: the old entries are read in order, the new
// range is slipped into the stream at its sorted place (after all entries that
// do not sort after it), and every element of the stream is folded into an
// accumulator. When an element does not touch the accumulator, the accumulator
// is written back at the write pointer, which never overtakes the read pointer,
// so the table is rewritten in place.
module sorted_merged_range_table #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  input  logic [6:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  entry_count_o,
  output logic [31:0] entry_low_o,
  output logic [31:0] entry_high_o
);
  import smrt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned XW = (AW > 7) ? AW : 7;
  // An insert is refused once the count has reached this value.
  localparam logic [AW-1:0] FullCount = AW'(TABLE_DEPTH - 1);

  // Sequencer and pointers.
  smrt_state_e state_q, state_d;
  logic [AW-1:0] count_q;
  logic [AW-1:0] r_q;
  logic [AW-1:0] w_q;
  logic          ins_done_q;
  logic          acc_valid_q;
  logic          out_valid_q;

  // Payload registers.
  span_t         new_q;
  span_t         acc_q;
  span_t         item_q;
  span_t         res_span_q;
  status_e       res_status_q;
  logic [AW-1:0] idx_q;
  status_e       out_status_q;
  logic [6:0]    out_count_q;
  span_t         out_span_q;

  // Store and compare unit hookup.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  span_t         rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  span_t         wr_data;
  span_t         cmp_a;
  span_t         cmp_b;
  cmp_res_t      cmp_res;

  logic          in_accept;
  logic          out_free;
  logic          idx_in_range;
  logic          table_full;
  logic          take_old;
  logic          take_new;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] count_x;

  smrt_store #(
    .Depth (TABLE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  smrt_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign idx_x        = XW'(entry_index_i);
  assign count_x      = XW'(count_q);
  assign idx_in_range = idx_x < count_x;
  assign table_full   = count_q >= FullCount;

  // Take the next old entry unless the new range still has to go before it.
  assign take_old = (r_q < count_q) && (ins_done_q || !cmp_res.after);
  assign take_new = !take_old && !ins_done_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (operation_i == OpRead) begin
            state_d = idx_in_range ? S_RD_REQ : S_RESP;
          end else begin
            state_d = table_full ? S_RESP : S_INS_RD;
          end
        end
      end
      S_INS_RD:    state_d = S_INS_CMP;
      S_INS_CMP: begin
        state_d = (take_old || take_new) ? S_INS_MERGE : S_INS_FLUSH;
      end
      S_INS_MERGE: state_d = S_INS_CMP;
      S_INS_FLUSH: state_d = S_RESP;
      S_RD_REQ:    state_d = S_RD_DATA;
      S_RD_DATA:   state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Store ports and compare operands.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = r_q;
    wr_en   = 1'b0;
    wr_addr = w_q;
    wr_data = acc_q;
    cmp_a   = rd_data;
    cmp_b   = new_q;
    case (state_q)
      S_INS_RD: begin
        rd_en = 1'b1;
      end
      S_INS_CMP: begin
        // Prefetch the following entry while the chosen one is folded.
        if (take_old) begin
          rd_en   = 1'b1;
          rd_addr = r_q + AW'(1);
        end
      end
      S_INS_MERGE: begin
        cmp_a = acc_q;
        cmp_b = item_q;
        wr_en = acc_valid_q && !cmp_res.touch;
      end
      S_INS_FLUSH: begin
        wr_en = 1'b1;
      end
      S_RD_REQ: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      r_q         <= '0;
      w_q         <= '0;
      ins_done_q  <= 1'b0;
      acc_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new result may replace one that leaves in the same cycle.
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            r_q         <= '0;
            w_q         <= '0;
            ins_done_q  <= 1'b0;
            acc_valid_q <= 1'b0;
          end
        end
        S_INS_CMP: begin
          if (take_old) begin
            r_q <= r_q + AW'(1);
          end else if (take_new) begin
            ins_done_q <= 1'b1;
          end
        end
        S_INS_MERGE: begin
          if (!acc_valid_q) begin
            acc_valid_q <= 1'b1;
          end else if (!cmp_res.touch) begin
            w_q <= w_q + AW'(1);
          end
        end
        S_INS_FLUSH: begin
          count_q <= w_q + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          new_q      <= '{lo: range_low_i, hi: range_high_i};
          idx_q      <= AW'(entry_index_i);
          res_span_q <= '0;
          if (operation_i == OpRead) begin
            res_status_q <= idx_in_range ? STATUS_OK : STATUS_RANGE;
          end else begin
            res_status_q <= table_full ? STATUS_FULL : STATUS_OK;
          end
        end
      end
      S_INS_CMP: begin
        if (take_old) begin
          item_q <= rd_data;
        end else if (take_new) begin
          item_q <= new_q;
        end
      end
      S_INS_MERGE: begin
        if (!acc_valid_q || !cmp_res.touch) begin
          acc_q <= item_q;
        end else if (cmp_res.hi_less) begin
          acc_q.hi <= item_q.hi;
        end
      end
      S_RD_DATA: begin
        res_span_q <= rd_data;
      end
      S_RESP: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_count_q  <= count_x[6:0];
          out_span_q   <= res_span_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign entry_low_o   = out_span_q.lo;
  assign entry_high_o  = out_span_q.hi;

  // The count never reaches the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("range count exceeds table capacity");

  // In-place rewrite: the write pointer stays behind the read pointer.
  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_MERGE && acc_valid_q) |-> (w_q < r_q))
    else $error("write pointer overtook read pointer");

  // The final write lands no further than one past the old table.
  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_FLUSH) |-> (w_q <= count_q))
    else $error("flush beyond old table end");

  // An insert only finishes after the new range has entered the stream.
  a_flush_inserted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_FLUSH) |-> (ins_done_q && acc_valid_q))
    else $error("flush without the new range");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Range table testbench
// Drives insert and read beats into the sorted merged range table. A
// predictor keeps its own copy of the table and works out the result beat
// for every accepted request, and a checker compares each result beat field
// by field against the oldest outstanding expectation. Both channels idle at
// random, and a long output hold-off makes the table back up its input.
// ============================================================================
module tb_top;
  import smrt_pkg::*;

  localparam int unsigned TableDepth = 128;
  // Chance, in percent, that a side idles in any given cycle.
  localparam int unsigned IdlePct = 29;
  // Length of the deliberate output hold-off, in cycles.
  localparam int unsigned HoldCycles = 400;
  // The longest insert goes into a table of 126 entries; this drain time
  // comfortably covers the last beat in flight.
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned RandomItems = 250;

  // One result beat, as the predictor expects it.
  typedef struct {
    status_e     status;
    logic [6:0]  count;
    logic [31:0] lo;
    logic [31:0] hi;
  } table_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OpInsert;
  logic [31:0] range_low_i = '0;
  logic [31:0] range_high_i = '0;
  logic [6:0]  entry_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [6:0]  entry_count_o;
  logic [31:0] entry_low_o;
  logic [31:0] entry_high_o;

  // Predicted contents of the table. The scratch copy lets an insert be
  // tried out without committing it.
  span_t       range_table [TableDepth];
  span_t       scratch_table [TableDepth];
  int unsigned table_count = 0;

  table_result_t expected_results [$];
  int unsigned   mismatch_count = 0;

  // When set, neither side idles at random.
  bit          no_idle = 1'b0;
  // The hold-off is requested by bumping this counter; the receiver process
  // notices the difference and serves the request on its own.
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  sorted_merged_range_table #(
    .TABLE_DEPTH(TableDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .entry_index_i(entry_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .entry_low_o  (entry_low_o),
    .entry_high_o (entry_high_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // True when a belongs after b: by lower bound first, then by upper bound.
  function automatic bit sorts_after(span_t a, span_t b);
    if (a.lo != b.lo) return a.lo > b.lo;
    return a.hi > b.hi;
  endfunction

  // A range with a lower bound of zero always touches what comes before it;
  // otherwise it touches when the predecessor reaches at least lo - 1. The
  // zero case must not wrap around to the top of the address space.
  function automatic bit touches(span_t prev, span_t next);
    if (next.lo == 32'd0) return 1'b1;
    return prev.hi >= next.lo - 32'd1;
  endfunction

  // Appends the new range to a scratch copy of the table, sorts the copy and
  // folds every entry that touches its predecessor. Returns the new count.
  // The caller makes sure the table has room for one more entry.
  function automatic int unsigned fold_into_scratch(span_t fresh);
    int unsigned n;
    int unsigned i;
    int unsigned q;
    int unsigned k;
    span_t       tmp;
    for (k = 0; k < table_count; k++) scratch_table[k] = range_table[k];
    scratch_table[table_count] = fresh;
    n = table_count + 1;
    // Insertion sort; only the new entry is really out of place.
    for (i = 1; i < n; i++) begin
      for (q = i; q > 0 && sorts_after(scratch_table[q-1], scratch_table[q]); q--) begin
        tmp = scratch_table[q];
        scratch_table[q] = scratch_table[q-1];
        scratch_table[q-1] = tmp;
      end
    end
    // Fold pass: absorb touching entries and close the gap behind them.
    for (i = 1; i < n; i++) begin
      while (i < n && touches(scratch_table[i-1], scratch_table[i])) begin
        if (scratch_table[i-1].hi < scratch_table[i].hi) begin
          scratch_table[i-1].hi = scratch_table[i].hi;
        end
        for (k = i + 1; k < n; k++) scratch_table[k-1] = scratch_table[k];
        n--;
      end
    end
    return n;
  endfunction

  // Works out the result beat of one request and updates the predicted table.
  function automatic table_result_t predict_table_op(logic op, logic [31:0] lo,
                                                     logic [31:0] hi, logic [6:0] idx);
    table_result_t r;
    span_t         fresh;
    r.status = STATUS_OK;
    r.lo = '0;
    r.hi = '0;
    if (op == OpInsert) begin
      // The last slot is never filled: an insert needs count + 1 below depth.
      if (table_count + 1 < TableDepth) begin
        fresh.lo = lo;
        fresh.hi = hi;
        table_count = fold_into_scratch(fresh);
        for (int k = 0; k < table_count; k++) range_table[k] = scratch_table[k];
      end else begin
        r.status = STATUS_FULL;
      end
    end else if (idx < table_count) begin
      r.lo = range_table[idx].lo;
      r.hi = range_table[idx].hi;
    end else begin
      r.status = STATUS_RANGE;
    end
    r.count = table_count[6:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offers one request beat at a falling edge, after an optional random gap,
  // and returns at the rising edge where it is taken. Valid stays high on
  // return so that back-to-back beats need no extra cycle; anything that
  // waits instead of sending must drop it first.
  task automatic send_request(input logic op, input logic [31:0] lo,
                              input logic [31:0] hi, input logic [6:0] idx);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    // Beats are taken in the order they are offered, so predicting here keeps
    // the expectations in acceptance order.
    expected_results.push_back(predict_table_op(op, lo, hi, idx));
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    range_low_i   <= lo;
    range_high_i  <= hi;
    entry_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drops valid and waits until every expected result beat has arrived.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------

  // Output stall, changed at the falling edge. A pending hold-off request
  // wins over everything else, then the random idling.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < IdlePct);
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Every result beat taken at a rising edge is matched with the oldest
  // expectation, one field at a time.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (code %0d count %0d)",
                                  status_o, entry_count_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status code %0d, expected %0d", status_o, want.status));
        end
        if (entry_count_o !== want.count) begin
          report_mismatch($sformatf("entry count %0d, expected %0d", entry_count_o, want.count));
        end
        if (entry_low_o !== want.lo) begin
          report_mismatch($sformatf("entry low %h, expected %h", entry_low_o, want.lo));
        end
        if (entry_high_o !== want.hi) begin
          report_mismatch($sformatf("entry high %h, expected %h", entry_high_o, want.hi));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reads from an empty table are all out of range, including the top index.
  task automatic test_empty_table();
    send_request(OpRead, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0);
    send_request(OpRead, 32'h0000_0000, 32'h0000_0000, 7'd127);
    wait_for_results();
  endtask

  // Hand-picked inserts for the extremes of the bounds, merging at zero,
  // adjacency, overlap, nesting and reversed ranges, followed by read-back.
  task automatic test_directed_inserts();
    // A point at zero, then a range with the same zero lower bound: the
    // zero lower bound must count as touching and fold the two together.
    send_request(OpInsert, 32'h0000_0000, 32'h0000_0000, 7'd0);
    send_request(OpInsert, 32'h0000_0000, 32'h0000_0007, 7'd0);
    // The very top of the address space, then one just below it.
    send_request(OpInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
    send_request(OpInsert, 32'hFFFF_FFFD, 32'hFFFF_FFFE, 7'd0);
    // Adjacent to [0, 7]: folds into it.
    send_request(OpInsert, 32'h0000_0008, 32'h0000_000A, 7'd0);
    // Apart by one address: stays separate, then gets bridged by an overlap.
    send_request(OpInsert, 32'h0000_0010, 32'h0000_0020, 7'd0);
    send_request(OpInsert, 32'h0000_0022, 32'h0000_0030, 7'd0);
    send_request(OpInsert, 32'h0000_001C, 32'h0000_0023, 7'd0);
    // Nested inside an existing range: the upper bound must not drop.
    send_request(OpInsert, 32'h0000_0012, 32'h0000_0014, 7'd0);
    // Reversed ranges are kept as given.
    send_request(OpInsert, 32'h0000_1000, 32'h0000_0800, 7'd0);
    send_request(OpInsert, 32'h8000_0000, 32'h0000_0001, 7'd0);
    send_request(OpInsert, 32'h0000_0FFF, 32'h0000_0FFF, 7'd0);
    send_request(OpInsert, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7'd0);
    // Read back every entry, then just past the end and the top index.
    for (int k = 0; k < table_count; k++) begin
      send_request(OpRead, $urandom, $urandom, 7'(k));
    end
    send_request(OpRead, 32'h0, 32'h0, 7'(table_count));
    send_request(OpRead, 32'h0, 32'h0, 7'd127);
    wait_for_results();
  endtask

  // Mixed traffic. Nearly half the inserts land in a few clusters, to merge
  // with each other often; the rest are scattered, reversed, at the edges of
  // the address space or fully random. Part of the run goes without idling.
  task automatic test_random_traffic();
    logic [31:0] cluster_base [4];
    logic [31:0] lo;
    logic [31:0] hi;
    logic [6:0]  idx;
    int unsigned kind;
    cluster_base[0] = 32'h0;
    for (int c = 1; c < 4; c++) cluster_base[c] = $urandom & 32'hFFFF_0000;
    for (int n = 0; n < RandomItems; n++) begin
      no_idle = (n >= 100 && n < 180);
      if ($urandom_range(0, 99) < 55) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          lo = cluster_base[$urandom_range(0, 3)] + $urandom_range(0, 4095);
          hi = lo + $urandom_range(0, 255);
        end else if (kind < 75) begin
          lo = $urandom;
          hi = lo + $urandom_range(0, 1023);
        end else if (kind < 85) begin
          hi = $urandom;
          lo = hi + $urandom_range(1, 65535);
        end else if (kind < 95) begin
          case ($urandom_range(0, 3))
            0: begin lo = 32'h0; hi = $urandom_range(0, 4095); end
            1: begin lo = $urandom; hi = 32'hFFFF_FFFF; end
            2: begin lo = 32'h0; hi = 32'h0; end
            default: begin lo = 32'hFFFF_FFFF; hi = 32'hFFFF_FFFF; end
          endcase
        end else begin
          lo = $urandom;
          hi = $urandom;
        end
        send_request(OpInsert, lo, hi, 7'($urandom));
      end else begin
        if (table_count != 0 && $urandom_range(0, 99) < 80) begin
          idx = 7'($urandom_range(0, table_count - 1));
        end else begin
          idx = 7'($urandom_range(0, 127));
        end
        send_request(OpRead, $urandom, $urandom, idx);
      end
    end
    no_idle = 1'b0;
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // short reads, so the result register and the sequencer fill up and the
  // input channel has to stall.
  task automatic test_output_backpressure();
    no_idle = 1'b1;
    hold_requests++;
    for (int n = 0; n < 12; n++) begin
      send_request(OpRead, $urandom, $urandom, 7'($urandom_range(0, 127)));
    end
    no_idle = 1'b0;
    wait_for_results();
  endtask

  // Fills the table with isolated points until only the reserved slot is
  // left, then checks that inserts are refused and the contents hold.
  task automatic test_table_full();
    span_t       probe;
    int unsigned tries;
    tries = 0;
    while (table_count + 1 < TableDepth && tries < 20000) begin
      // Even points never touch each other; try each one on the scratch
      // copy first and only send those that add an entry.
      probe.lo = $urandom & 32'hFFFF_FFFE;
      probe.hi = probe.lo;
      tries++;
      if (fold_into_scratch(probe) > table_count) begin
        send_request(OpInsert, probe.lo, probe.hi, 7'($urandom));
      end
    end
    // Refused inserts, including one that repeats an existing entry.
    send_request(OpInsert, 32'h0000_0000, 32'hFFFF_FFFF, 7'd0);
    send_request(OpInsert, range_table[0].lo, range_table[0].hi, 7'd0);
    send_request(OpInsert, $urandom, $urandom, 7'($urandom));
    send_request(OpInsert, 32'hFFFF_FFFF, 32'h0000_0000, 7'h7F);
    for (int n = 0; n < 30; n++) begin
      send_request(OpRead, $urandom, $urandom, 7'($urandom_range(0, 127)));
    end
    send_request(OpRead, 32'h0, 32'h0, 7'd126);
    send_request(OpRead, 32'h0, 32'h0, 7'd127);
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    // Reset is held low from the start and released at a falling edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_directed_inserts();
    test_random_traffic();
    test_output_backpressure();
    // Once full the table can never shrink again, so this runs last.
    test_table_full();

    // Give any stray beat time to show up before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a quarter of this.
  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule
